>>> rtl/slnorm_pkg.sv
package slnorm_pkg;

	// Lexer modes.
	localparam logic [2:0] MODE_PLAIN    = 3'd0;
	localparam logic [2:0] MODE_SINGLE   = 3'd1;
	localparam logic [2:0] MODE_DOUBLE   = 3'd2;
	localparam logic [2:0] MODE_VERBATIM = 3'd3;
	localparam logic [2:0] MODE_BACKTICK = 3'd4;
	localparam logic [2:0] MODE_ESCAPE   = 3'd5;

	// Escape return selector.
	localparam logic RET_SINGLE = 1'b0;
	localparam logic RET_DOUBLE = 1'b1;

	// Characters of interest.
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_BTICK  = 8'h60;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_F      = 8'h66;
	localparam logic [7:0] CH_V      = 8'h76;
	localparam logic [7:0] CH_T      = 8'h74;

	// Control bytes produced by escapes.
	localparam logic [7:0] CTL_LF = 8'h0A;
	localparam logic [7:0] CTL_CR = 8'h0D;
	localparam logic [7:0] CTL_FF = 8'h0C;
	localparam logic [7:0] CTL_VT = 8'h0B;
	localparam logic [7:0] CTL_HT = 8'h09;

	// Number of result beats caused by one item.
	localparam logic [1:0] CNT_NONE = 2'd0;
	localparam logic [1:0] CNT_ONE  = 2'd1;
	localparam logic [1:0] CNT_TWO  = 2'd2;

	// Outcome of translating one item against the current mode.
	typedef struct packed {
		logic [1:0] cnt;
		logic [7:0] c0;
		logic       bad;
		logic [7:0] c1;
		logic [2:0] mode;
		logic       ret_we;
		logic       ret;
	} xlate_t;

endpackage

>>> rtl/string_literal_normalizer.sv
// String literal normalizer.
// Source text enters one byte per beat on the item channel (char_in, with
// end_of_text marking the end of input). Rewritten text leaves on the result
// channel (char_out, bad_escape, last); every string literal comes out in
// double quotes. An input beat causes zero, one or two result beats, and
// last is set on the final result beat of each input beat.
// Path: an accepted byte is held in the input register until the result
// register can take it, then translated against the current mode and
// written to the result register, which offers its result beats.
// Throughput: one input byte per cycle while each byte gives at most one
// result and the receiver takes every beat. A byte that gives two result
// beats keeps the next byte waiting until both beats are taken.
// Reset brings the block to plain text with both registers empty.
// When the receiver stalls, the result register holds its beat and the
// input register fills; item_ready then drops until the result register
// can take the held byte again. Nothing is dropped or repeated.
module string_literal_normalizer
	import slnorm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_ready,
	input  logic [7:0] char_in,
	input  logic       end_of_text,
	output logic       result_valid,
	input  logic       result_ready,
	output logic [7:0] char_out,
	output logic       bad_escape,
	output logic       last
);

	// Input register.
	logic       valid_s1;
	logic [7:0] char_s1;
	logic       eot_s1;

	// Mode state; the return selector is always written before it is read.
	logic [2:0] mode_q;
	logic       ret_q;

	// Result register: up to two beats, head shown on the ports.
	logic [1:0] cnt_q;
	logic [7:0] head_q;
	logic       head_bad_q;
	logic [7:0] tail_q;

	xlate_t xo;
	logic   pop;
	logic   load_ok;
	logic   advance;

	slnorm_xlate u_xlate (
		.mode        (mode_q),
		.ret         (ret_q),
		.char_in     (char_s1),
		.end_of_text (eot_s1),
		.xo          (xo)
	);

	assign result_valid = (cnt_q != CNT_NONE);
	assign char_out     = head_q;
	assign bad_escape   = head_bad_q;
	assign last         = (cnt_q == CNT_ONE);

	assign pop        = result_valid && result_ready;
	// The result register can take a new item when it will be empty.
	assign load_ok    = (cnt_q == CNT_NONE) || (cnt_q == CNT_ONE && pop);
	assign advance    = valid_s1 && load_ok;
	assign item_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			char_s1 <= char_in;
			eot_s1  <= end_of_text;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_PLAIN;
		end else if (advance) begin
			mode_q <= xo.mode;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && xo.ret_we) begin
			ret_q <= xo.ret;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= CNT_NONE;
		end else if (advance) begin
			cnt_q <= xo.cnt;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			head_q     <= xo.c0;
			head_bad_q <= xo.bad;
			tail_q     <= xo.c1;
		end else if (pop && cnt_q == CNT_TWO) begin
			// Second beat of a pair moves to the head.
			head_q     <= tail_q;
			head_bad_q <= 1'b0;
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("result count out of range");

	a_mode_range: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q != 3'd6 && mode_q != 3'd7)
		else $error("unused mode code reached");

	a_held_item: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && cnt_q == CNT_TWO) |=> valid_s1)
		else $error("input beat lost while result pair pending");

	a_bad_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && bad_escape) |-> last)
		else $error("error result not final");

endmodule

>>> rtl/slnorm_xlate.sv
module slnorm_xlate
	import slnorm_pkg::*;
(
	input  logic [2:0] mode,
	input  logic       ret,
	input  logic [7:0] char_in,
	input  logic       end_of_text,
	output xlate_t     xo
);

	always_comb begin
		xo        = '0;
		xo.mode   = mode;
		xo.ret    = ret;
		xo.ret_we = 1'b0;
		if (end_of_text) begin
			// Only a pending backtick in a verbatim string needs closing.
			if (mode == MODE_BACKTICK) begin
				xo.cnt  = CNT_ONE;
				xo.c0   = CH_DQUOTE;
				xo.mode = MODE_PLAIN;
			end
		end else begin
			unique case (mode)
				MODE_SINGLE: begin
					if (char_in == CH_SQUOTE) begin
						xo.cnt  = CNT_ONE;
						xo.c0   = CH_DQUOTE;
						xo.mode = MODE_PLAIN;
					end else if (char_in == CH_DQUOTE || char_in == CH_BTICK) begin
						xo.cnt = CNT_TWO;
						xo.c0  = CH_DQUOTE;
						xo.c1  = CH_DQUOTE;
					end else if (char_in == CH_BSLASH) begin
						xo.ret_we = 1'b1;
						xo.ret    = RET_SINGLE;
						xo.mode   = MODE_ESCAPE;
					end else begin
						xo.cnt = CNT_ONE;
						xo.c0  = char_in;
					end
				end
				MODE_DOUBLE: begin
					if (char_in == CH_DQUOTE) begin
						xo.cnt  = CNT_ONE;
						xo.c0   = CH_DQUOTE;
						xo.mode = MODE_PLAIN;
					end else if (char_in == CH_BSLASH) begin
						xo.ret_we = 1'b1;
						xo.ret    = RET_DOUBLE;
						xo.mode   = MODE_ESCAPE;
					end else begin
						xo.cnt = CNT_ONE;
						xo.c0  = char_in;
					end
				end
				MODE_VERBATIM: begin
					if (char_in == CH_BTICK) begin
						xo.mode = MODE_BACKTICK;
					end else if (char_in == CH_DQUOTE) begin
						xo.cnt = CNT_TWO;
						xo.c0  = CH_DQUOTE;
						xo.c1  = CH_DQUOTE;
					end else begin
						xo.cnt = CNT_ONE;
						xo.c0  = char_in;
					end
				end
				MODE_BACKTICK: begin
					if (char_in == CH_BTICK) begin
						xo.cnt  = CNT_ONE;
						xo.c0   = CH_BTICK;
						xo.mode = MODE_VERBATIM;
					end else begin
						xo.cnt  = CNT_TWO;
						xo.c0   = CH_DQUOTE;
						xo.c1   = char_in;
						xo.mode = MODE_PLAIN;
					end
				end
				MODE_ESCAPE: begin
					xo.cnt  = CNT_ONE;
					xo.mode = (ret == RET_DOUBLE) ? MODE_DOUBLE : MODE_SINGLE;
					case (char_in)
						CH_N:      xo.c0 = CTL_LF;
						CH_R:      xo.c0 = CTL_CR;
						CH_F:      xo.c0 = CTL_FF;
						CH_V:      xo.c0 = CTL_VT;
						CH_T:      xo.c0 = CTL_HT;
						CH_DQUOTE: begin
							xo.cnt = CNT_TWO;
							xo.c0  = CH_DQUOTE;
							xo.c1  = CH_DQUOTE;
						end
						default: begin
							// Unknown escape: report it and stay in escape mode.
							xo.bad  = 1'b1;
							xo.mode = mode;
						end
					endcase
				end
				default: begin
					// Plain text; unused codes behave the same way.
					xo.cnt = CNT_ONE;
					if (char_in == CH_SQUOTE) begin
						xo.c0   = CH_DQUOTE;
						xo.mode = MODE_SINGLE;
					end else if (char_in == CH_DQUOTE) begin
						xo.c0   = CH_DQUOTE;
						xo.mode = MODE_DOUBLE;
					end else if (char_in == CH_BTICK) begin
						xo.c0   = CH_DQUOTE;
						xo.mode = MODE_VERBATIM;
					end else begin
						xo.c0   = char_in;
						xo.mode = MODE_PLAIN;
					end
				end
			endcase
		end
	end

endmodule

>>> dv/string_literal_normalizer_test.sv
// Self-checking bench for the string literal normalizer.
module string_literal_normalizer_test
	import slnorm_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	// Bytes that only the stimulus needs: the unfinished unicode escapes.
	localparam logic [7:0] ESC_LOWER_U = 8'h75;
	localparam logic [7:0] ESC_UPPER_U = 8'h55;

	localparam int RANDOM_TEXT  = 400;
	localparam int HOLD_SPACING = 150;
	localparam int STUCK_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 20;

	// One beat on the result channel.
	typedef struct packed {
		logic [7:0] ch;
		logic       bad;
		logic       last;
	} out_beat_t;

	// One beat on the item channel. hold_off makes the sender wait until
	// every awaited result beat has come back before offering this one.
	typedef struct packed {
		logic [7:0] ch;
		logic       eot;
		logic       hold_off;
	} text_item_t;

	logic       clk          = 1'b0;
	logic       arst_n       = 1'b0;
	logic       item_valid   = 1'b0;
	logic       item_ready;
	logic [7:0] char_in      = 8'h00;
	logic       end_of_text  = 1'b0;
	logic       result_valid;
	logic       result_ready = 1'b0;
	logic [7:0] char_out;
	logic       bad_escape;
	logic       last;

	string_literal_normalizer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.char_in      (char_in),
		.end_of_text  (end_of_text),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.char_out     (char_out),
		.bad_escape   (bad_escape),
		.last         (last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Source text still to be sent, and result beats the predictor has
	// worked out but the block has not yet delivered, oldest first.
	text_item_t source_text[$];
	out_beat_t  awaited_output[$];

	// The predictor's copy of the lexer state. The escape return selector
	// is only read after a backslash inside a quoted string has set it.
	logic [2:0] lex_mode   = MODE_PLAIN;
	logic       esc_return = RET_SINGLE;

	int         errors       = 0;
	int         stuck_cycles = 0;
	int         text_items   = 0;
	logic       hold_next    = 1'b0;
	text_item_t next_item;
	int         burst_left   = 0;
	int         gap_left     = 0;
	int         style_left   = 0;
	int         stall_style  = 0;
	logic [3:0] stall_phase  = 4'd0;

	task automatic push_beat(input logic [7:0] ch, input logic bad, input logic fin);
		awaited_output.push_back('{ch: ch, bad: bad, last: fin});
	endtask

	// Advance the lexer by one accepted item and queue the result beats it
	// causes. Two-beat results are queued in the order they leave the block.
	task automatic normalize_item(input logic [7:0] ch, input logic eot);
		logic [7:0] ctl;
		logic       known;
		ctl = 8'h00;
		known = 1'b1;
		if (eot) begin
			// End of text only matters when a verbatim string waits on a
			// possible closing backtick; it then closes the string.
			if (lex_mode == MODE_BACKTICK) begin
				lex_mode = MODE_PLAIN;
				push_beat(CH_DQUOTE, 1'b0, 1'b1);
			end
		end else begin
			case (lex_mode)
				MODE_SINGLE: begin
					if (ch == CH_SQUOTE) begin
						lex_mode = MODE_PLAIN;
						push_beat(CH_DQUOTE, 1'b0, 1'b1);
					end else if (ch == CH_DQUOTE || ch == CH_BTICK) begin
						push_beat(CH_DQUOTE, 1'b0, 1'b0);
						push_beat(CH_DQUOTE, 1'b0, 1'b1);
					end else if (ch == CH_BSLASH) begin
						esc_return = RET_SINGLE;
						lex_mode = MODE_ESCAPE;
					end else begin
						push_beat(ch, 1'b0, 1'b1);
					end
				end
				MODE_DOUBLE: begin
					if (ch == CH_DQUOTE) begin
						lex_mode = MODE_PLAIN;
						push_beat(CH_DQUOTE, 1'b0, 1'b1);
					end else if (ch == CH_BSLASH) begin
						esc_return = RET_DOUBLE;
						lex_mode = MODE_ESCAPE;
					end else begin
						push_beat(ch, 1'b0, 1'b1);
					end
				end
				MODE_VERBATIM: begin
					if (ch == CH_BTICK) begin
						lex_mode = MODE_BACKTICK;
					end else if (ch == CH_DQUOTE) begin
						push_beat(CH_DQUOTE, 1'b0, 1'b0);
						push_beat(CH_DQUOTE, 1'b0, 1'b1);
					end else begin
						push_beat(ch, 1'b0, 1'b1);
					end
				end
				MODE_BACKTICK: begin
					if (ch == CH_BTICK) begin
						lex_mode = MODE_VERBATIM;
						push_beat(CH_BTICK, 1'b0, 1'b1);
					end else begin
						lex_mode = MODE_PLAIN;
						push_beat(CH_DQUOTE, 1'b0, 1'b0);
						push_beat(ch, 1'b0, 1'b1);
					end
				end
				MODE_ESCAPE: begin
					case (ch)
						CH_N:      ctl = CTL_LF;
						CH_R:      ctl = CTL_CR;
						CH_F:      ctl = CTL_FF;
						CH_V:      ctl = CTL_VT;
						CH_T:      ctl = CTL_HT;
						CH_DQUOTE: ctl = CH_DQUOTE;
						default:   known = 1'b0;
					endcase
					// An unknown escape leaves the lexer waiting on an escape.
					if (!known) begin
						push_beat(8'h00, 1'b1, 1'b1);
					end else begin
						lex_mode = (esc_return == RET_DOUBLE) ? MODE_DOUBLE : MODE_SINGLE;
						if (ch == CH_DQUOTE) begin
							push_beat(CH_DQUOTE, 1'b0, 1'b0);
							push_beat(CH_DQUOTE, 1'b0, 1'b1);
						end else begin
							push_beat(ctl, 1'b0, 1'b1);
						end
					end
				end
				default: begin
					if (ch == CH_SQUOTE) lex_mode = MODE_SINGLE;
					else if (ch == CH_DQUOTE) lex_mode = MODE_DOUBLE;
					else if (ch == CH_BTICK) lex_mode = MODE_VERBATIM;
					else lex_mode = MODE_PLAIN;
					if (ch == CH_SQUOTE || ch == CH_DQUOTE || ch == CH_BTICK) begin
						push_beat(CH_DQUOTE, 1'b0, 1'b1);
					end else begin
						push_beat(ch, 1'b0, 1'b1);
					end
				end
			endcase
		end
	endtask

	task automatic add_byte(input logic [7:0] ch);
		source_text.push_back('{ch: ch, eot: 1'b0, hold_off: hold_next});
		hold_next = 1'b0;
		text_items++;
	endtask

	task automatic add_end();
		source_text.push_back('{ch: 8'($urandom_range(0, 255)), eot: 1'b1, hold_off: hold_next});
		hold_next = 1'b0;
	endtask

	// Any byte that is neither a string delimiter nor a backslash.
	function automatic logic [7:0] random_text_byte();
		logic [7:0] b;
		b = 8'($urandom_range(0, 255));
		while (b == CH_SQUOTE || b == CH_DQUOTE || b == CH_BTICK || b == CH_BSLASH)
			b = 8'($urandom_range(0, 255));
		return b;
	endfunction

	function automatic logic [7:0] good_escape_byte();
		logic [7:0] b;
		case ($urandom_range(0, 5))
			0:       b = CH_N;
			1:       b = CH_R;
			2:       b = CH_F;
			3:       b = CH_V;
			4:       b = CH_T;
			default: b = CH_DQUOTE;
		endcase
		return b;
	endfunction

	// Bytes that are not a supported escape, favoring the unicode prefixes,
	// a second backslash and a single quote.
	function automatic logic [7:0] random_bad_escape();
		logic [7:0] b;
		case ($urandom_range(0, 5))
			0:       b = ESC_LOWER_U;
			1:       b = ESC_UPPER_U;
			2:       b = CH_BSLASH;
			3:       b = CH_SQUOTE;
			default: begin
				b = 8'($urandom_range(0, 255));
				while (b == CH_N || b == CH_R || b == CH_F || b == CH_V || b == CH_T ||
						b == CH_DQUOTE)
					b = 8'($urandom_range(0, 255));
			end
		endcase
		return b;
	endfunction

	// A single- or double-quoted string with random content. Now and then
	// the closing quote is left off, so the text that follows lands inside.
	task automatic add_quoted(input logic [7:0] delim);
		add_byte(delim);
		repeat ($urandom_range(0, 8)) begin
			case ($urandom_range(0, 9))
				0: add_byte((delim == CH_SQUOTE) ? CH_DQUOTE : CH_SQUOTE);
				1: add_byte(CH_BTICK);
				2, 3: begin
					add_byte(CH_BSLASH);
					add_byte(good_escape_byte());
				end
				4: begin
					add_byte(CH_BSLASH);
					repeat ($urandom_range(1, 2)) add_byte(random_bad_escape());
					add_byte(good_escape_byte());
				end
				default: add_byte(random_text_byte());
			endcase
		end
		if ($urandom_range(0, 9) != 0) add_byte(delim);
	endtask

	// A verbatim string, closed by a backtick followed by either ordinary
	// text or the end of text.
	task automatic add_verbatim();
		add_byte(CH_BTICK);
		repeat ($urandom_range(0, 8)) begin
			case ($urandom_range(0, 5))
				0: add_byte(CH_DQUOTE);
				1: begin
					add_byte(CH_BTICK);
					add_byte(CH_BTICK);
				end
				default: add_byte(random_text_byte());
			endcase
		end
		add_byte(CH_BTICK);
		if ($urandom_range(0, 3) == 0) add_end();
		else add_byte(random_text_byte());
	endtask

	task automatic build_source_text();
		int next_hold;
		// Directed part. Plain text at both byte extremes, and an end of text
		// that finds nothing pending.
		add_byte(8'h00);
		add_byte(8'hFF);
		add_end();
		// Single-quoted: a double quote and a backtick both come out doubled.
		// Then a run of unknown escapes (both unicode prefixes, a backslash
		// and a single quote), each leaving the lexer in the escape, and a
		// newline escape that finally ends it; a vertical tab escape follows.
		add_byte(CH_SQUOTE);
		add_byte(CH_DQUOTE);
		add_byte(CH_BTICK);
		add_byte(CH_BSLASH);
		add_byte(ESC_LOWER_U);
		add_byte(ESC_UPPER_U);
		add_byte(CH_BSLASH);
		add_byte(CH_SQUOTE);
		add_byte(CH_N);
		add_byte(CH_BSLASH);
		add_byte(CH_V);
		add_byte(CH_SQUOTE);
		// Double-quoted: carriage return, form feed and tab escapes, and an
		// escaped double quote that comes out doubled and returns to the
		// double-quoted string.
		add_byte(CH_DQUOTE);
		add_byte(CH_BSLASH);
		add_byte(CH_R);
		add_byte(CH_BSLASH);
		add_byte(CH_F);
		add_byte(CH_BSLASH);
		add_byte(CH_T);
		add_byte(CH_BSLASH);
		add_byte(CH_DQUOTE);
		add_byte(CH_DQUOTE);
		// Verbatim: a double quote doubles, a doubled backtick gives one, and
		// a backtick before another byte closes the string ahead of that byte.
		add_byte(CH_BTICK);
		add_byte(8'h61);
		add_byte(CH_DQUOTE);
		add_byte(CH_BTICK);
		add_byte(CH_BTICK);
		add_byte(CH_BTICK);
		add_byte(8'h62);
		// Verbatim string left open with a backtick pending at end of text.
		add_byte(CH_BTICK);
		add_byte(CH_BTICK);
		add_end();

		// Random part: mostly well-formed literals with random content, with
		// some plain runs and raw noise in between. The first random beat and
		// one beat every so often wait for the block to run dry.
		text_items = 0;
		next_hold = HOLD_SPACING;
		hold_next = 1'b1;
		while (text_items < RANDOM_TEXT) begin
			if (text_items >= next_hold) begin
				hold_next = 1'b1;
				next_hold += HOLD_SPACING;
			end
			case ($urandom_range(0, 9))
				0, 1: repeat ($urandom_range(1, 5)) add_byte(random_text_byte());
				2, 3: add_quoted(CH_SQUOTE);
				4, 5: add_quoted(CH_DQUOTE);
				6, 7: add_verbatim();
				default: begin
					repeat ($urandom_range(1, 6)) begin
						if ($urandom_range(0, 7) == 0) add_end();
						else add_byte(8'($urandom_range(0, 255)));
					end
				end
			endcase
		end
	endtask

	// Sender. Beats go out in bursts of random length separated by random
	// gaps; a gap of zero joins two bursts into one unbroken stretch. Every
	// accepted beat is run through the predictor at the edge that takes it.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			char_in <= 8'h00;
			end_of_text <= 1'b0;
			burst_left <= 0;
			gap_left <= 0;
		end else begin
			if (item_valid && item_ready) normalize_item(char_in, end_of_text);
			// A new beat may be offered only once the current one is gone.
			if (!item_valid || item_ready) begin
				if (gap_left != 0) begin
					gap_left <= gap_left - 1;
					item_valid <= 1'b0;
				end else if (source_text.size() == 0 ||
						(source_text[0].hold_off && awaited_output.size() != 0)) begin
					item_valid <= 1'b0;
				end else begin
					next_item = source_text.pop_front();
					item_valid <= 1'b1;
					char_in <= next_item.ch;
					end_of_text <= next_item.eot;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 24);
						gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					end else begin
						burst_left <= burst_left - 1;
					end
				end
			end
		end
	end

	// Receiver. The stall style is redrawn whenever its random hold count
	// runs out: always ready, coin flip, mostly stalled, or one of two fixed
	// patterns driven by a free-running phase counter.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
			style_left <= 0;
			stall_style <= 0;
			stall_phase <= 4'd0;
		end else begin
			stall_phase <= stall_phase + 4'd1;
			if (style_left == 0) begin
				style_left <= $urandom_range(20, 200);
				stall_style <= $urandom_range(0, 4);
			end else begin
				style_left <= style_left - 1;
			end
			case (stall_style)
				0:       result_ready <= 1'b1;
				1:       result_ready <= 1'($urandom_range(0, 1));
				2:       result_ready <= ($urandom_range(0, 3) == 0);
				3:       result_ready <= (stall_phase[1:0] != 2'b11);
				default: result_ready <= (stall_phase == 4'd0);
			endcase
		end
	end

	// Checker. Each result beat must match the oldest awaited beat in every
	// field; a beat arriving with nothing awaited is a failure as well.
	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) begin
			if (awaited_output.size() == 0) begin
				$display("%0t: result beat with nothing awaited: char_out %h bad_escape %b last %b",
					$time, char_out, bad_escape, last);
				errors++;
			end else begin
				if (char_out !== awaited_output[0].ch) begin
					$display("%0t: char_out expected %h, got %h",
						$time, awaited_output[0].ch, char_out);
					errors++;
				end
				if (bad_escape !== awaited_output[0].bad) begin
					$display("%0t: bad_escape expected %b, got %b",
						$time, awaited_output[0].bad, bad_escape);
					errors++;
				end
				if (last !== awaited_output[0].last) begin
					$display("%0t: last expected %b, got %b",
						$time, awaited_output[0].last, last);
					errors++;
				end
				void'(awaited_output.pop_front());
			end
		end
	end

	// Watchdog: counts cycles in which neither channel moves a beat.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) stuck_cycles <= 0;
		else if ((item_valid && item_ready) || (result_valid && result_ready)) stuck_cycles <= 0;
		else stuck_cycles <= stuck_cycles + 1;
	end

	// Run control. Everything is sampled on the falling edge, well away from
	// the rising edge where the block and the bench update.
	initial begin
		build_source_text();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		while ((source_text.size() != 0 || item_valid || awaited_output.size() != 0) &&
				stuck_cycles < STUCK_LIMIT)
			@(negedge clk);
		if (stuck_cycles >= STUCK_LIMIT) begin
			$display("%0t: no beat moved for %0d cycles, %0d result beats still awaited",
				$time, stuck_cycles, awaited_output.size());
			$display("CHECK FAILED");
		end else begin
			// Give a stray extra result beat time to show up.
			repeat (DRAIN_CYCLES) @(negedge clk);
			if (errors == 0 && awaited_output.size() == 0) begin
				$display("CHECK OK");
			end else begin
				$display("CHECK FAILED");
			end
		end
		$finish;
	end

endmodule

>>> sim.f
rtl/slnorm_pkg.sv
rtl/slnorm_xlate.sv
rtl/string_literal_normalizer.sv
dv/string_literal_normalizer_test.sv
